>>> rtl/cdrom_toc_response_builder_core_macros.svh
// ----------------------------------------------------------------------------
// cdrom_toc_response_builder_core_macros.svh
// Assertion macros used by the checker of the TOC response builder.
// ----------------------------------------------------------------------------
`ifndef CDROM_TOC_RESPONSE_BUILDER_CORE_MACROS_SVH
`define CDROM_TOC_RESPONSE_BUILDER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CTRB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define CTRB_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    `CTRB_ASSERT(label, clk, rst_n, (cond) |-> (prop), msg)

`endif

>>> rtl/ctrb_pkg.sv
// ----------------------------------------------------------------------------
// ctrb_pkg
// Types, constants and reply tables of the READ TOC response builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctrb_pkg;

    localparam int CAP_W          = 32;
    localparam int SUM_W          = CAP_W + 1;
    localparam int LEAD_IN        = 150;
    localparam int FRAMES_PER_SEC = 75;
    localparam int SECS_PER_MIN   = 60;
    localparam int QUEUE_DEPTH    = 2;

    localparam int FMT_W      = 3;
    localparam int TRACK_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [FMT_W-1:0] FMT_TRACK   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_SESSION = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RAW     = 3'd2;
    localparam logic [FMT_W-1:0] FMT_TEXT    = 3'd5;

    typedef enum logic [2:0] {
        KIND_TRACK,
        KIND_SESSION,
        KIND_RAW,
        KIND_TEXT,
        KIND_REJECT
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  use_msf;
    } desc_t;

    typedef struct packed {
        logic [BYTE_W-1:0] m;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] f;
    } msf_t;

    typedef enum logic [2:0] {
        MSF_IDLE,
        MSF_MIN,
        MSF_REM,
        MSF_SEC,
        MSF_FRAME
    } msf_state_t;

    function automatic logic [IDX_W-1:0] last_index(input kind_t kind);
        logic [IDX_W-1:0] r;
        case (kind)
            KIND_TRACK:   r = 6'd19;
            KIND_SESSION: r = 6'd11;
            KIND_RAW:     r = 6'd47;
            KIND_TEXT:    r = 6'd3;
            default:      r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] reply_byte(
        input desc_t             d,
        input logic [IDX_W-1:0]  idx,
        input logic [CAP_W-1:0]  cap,
        input msf_t              lo
    );
        logic [BYTE_W-1:0] r;
        r = 8'h00;
        case (d.kind)
            KIND_TRACK:
            begin
                case (idx)
                    6'd1:    r = 8'd18;
                    6'd2:    r = 8'd1;
                    6'd3:    r = 8'd1;
                    6'd5:    r = 8'h15;
                    6'd6:    r = 8'h01;
                    6'd10:   r = d.use_msf ? 8'h02 : 8'h00;
                    6'd13:   r = 8'h16;
                    6'd14:   r = 8'hAA;
                    6'd16:   r = d.use_msf ? 8'h00 : cap[31:24];
                    6'd17:   r = d.use_msf ? lo.m : cap[23:16];
                    6'd18:   r = d.use_msf ? lo.s : cap[15:8];
                    6'd19:   r = d.use_msf ? lo.f : cap[7:0];
                    default: r = 8'h00;
                endcase
            end
            KIND_SESSION:
            begin
                case (idx)
                    6'd1:    r = 8'd10;
                    6'd2:    r = 8'd1;
                    6'd3:    r = 8'd1;
                    default: r = 8'h00;
                endcase
            end
            KIND_RAW:
            begin
                case (idx)
                    6'd1:    r = 8'd46;
                    6'd2:    r = 8'd1;
                    6'd3:    r = 8'd1;
                    // first-track pointer
                    6'd4:    r = 8'h01;
                    6'd5:    r = 8'h16;
                    6'd7:    r = 8'hA0;
                    6'd12:   r = 8'h01;
                    6'd13:   r = 8'h20;
                    // last-track pointer
                    6'd15:   r = 8'h01;
                    6'd16:   r = 8'h16;
                    6'd18:   r = 8'hA1;
                    6'd23:   r = 8'h01;
                    // lead-out pointer
                    6'd26:   r = 8'h01;
                    6'd27:   r = 8'h16;
                    6'd29:   r = 8'hA2;
                    6'd34:   r = lo.m;
                    6'd35:   r = lo.s;
                    6'd36:   r = lo.f;
                    // track 1 entry
                    6'd37:   r = 8'h01;
                    6'd38:   r = 8'h15;
                    6'd40:   r = 8'h01;
                    6'd46:   r = 8'h02;
                    default: r = 8'h00;
                endcase
            end
            KIND_TEXT:
            begin
                case (idx)
                    6'd1:    r = 8'd2;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ctrb_queue.sv
// ----------------------------------------------------------------------------
// ctrb_queue
// Short descriptor queue between request decode and reply generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrb_queue #(
    parameter int DEPTH = ctrb_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  ctrb_pkg::desc_t     push_desc,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output ctrb_pkg::desc_t     head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ctrb_pkg::desc_t   mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ctrb_front.sv
// ----------------------------------------------------------------------------
// ctrb_front
// Accepts READ TOC requests and sorts them into reply kinds.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrb_front (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ctrb_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              msf_busy,
    input  wire logic                              queue_full,
    output logic                                   push,
    output ctrb_pkg::desc_t                        push_desc
);

    logic [ctrb_pkg::FMT_W-1:0]   fmt;
    logic                         use_msf;
    logic [ctrb_pkg::TRACK_W-1:0] track;

    assign fmt     = s_tdata[2:0];
    assign use_msf = s_tdata[3];
    assign track   = s_tdata[11:4];

    // hold off requests while the lead-out address is being recomputed
    assign s_tready = !msf_busy && !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_desc.use_msf = use_msf;
        if (track > 8'd1)
        begin
            push_desc.kind = ctrb_pkg::KIND_REJECT;
        end
        else
        begin
            case (fmt)
                ctrb_pkg::FMT_TRACK:   push_desc.kind = ctrb_pkg::KIND_TRACK;
                ctrb_pkg::FMT_SESSION: push_desc.kind = ctrb_pkg::KIND_SESSION;
                ctrb_pkg::FMT_RAW:     push_desc.kind = ctrb_pkg::KIND_RAW;
                ctrb_pkg::FMT_TEXT:    push_desc.kind = ctrb_pkg::KIND_TEXT;
                default:               push_desc.kind = ctrb_pkg::KIND_REJECT;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/ctrb_msf.sv
// ----------------------------------------------------------------------------
// ctrb_msf
// Capacity register and conversion of capacity+150 into minute/second/frame
// by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrb_msf (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ctrb_pkg::CAP_W-1:0]     cfg_data,
    output logic [ctrb_pkg::CAP_W-1:0]          capacity,
    output ctrb_pkg::msf_t                      lead_out,
    output logic                                busy
);

    localparam int SUM_W      = ctrb_pkg::SUM_W;
    localparam int BYTE_W     = ctrb_pkg::BYTE_W;
    localparam int FPS        = ctrb_pkg::FRAMES_PER_SEC;
    localparam int FPM        = ctrb_pkg::FRAMES_PER_SEC * ctrb_pkg::SECS_PER_MIN;
    // frames per minute is a multiple of four: drop two bits before the multiply
    localparam int MIN_DIV    = FPM / 4;
    localparam int MIN_IN_W   = SUM_W - 2;
    localparam int MIN_SHIFT  = MIN_IN_W + $clog2(MIN_DIV);
    localparam int RECIP_W    = 32;
    localparam int MIN_PROD_W = MIN_IN_W + RECIP_W;
    localparam int MIN_Q_W    = MIN_PROD_W - MIN_SHIFT;
    localparam int REM_W      = $clog2(FPM);
    localparam int SEC_SHIFT  = REM_W + $clog2(FPS);
    localparam int SEC_PROD_W = REM_W + SEC_SHIFT;
    localparam logic [63:0] MIN_RECIP_L =
        ((64'd1 << MIN_SHIFT) + 64'(MIN_DIV) - 64'd1) / 64'(MIN_DIV);
    localparam logic [63:0] SEC_RECIP_L =
        ((64'd1 << SEC_SHIFT) + 64'(FPS) - 64'd1) / 64'(FPS);
    localparam logic [RECIP_W-1:0]   MIN_RECIP = MIN_RECIP_L[RECIP_W-1:0];
    localparam logic [SEC_SHIFT-1:0] SEC_RECIP = SEC_RECIP_L[SEC_SHIFT-1:0];
    localparam logic [SUM_W-1:0]     FPM_C     = SUM_W'(FPM);
    localparam logic [REM_W-1:0]     FPS_C     = REM_W'(FPS);

    ctrb_pkg::msf_state_t state_reg, state_next;
    logic [ctrb_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [SUM_W-1:0]           tot_reg, tot_next;
    logic [MIN_Q_W-1:0]         minq_reg, minq_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [BYTE_W-1:0]          sec_reg, sec_next;
    ctrb_pkg::msf_t             lo_reg, lo_next;

    logic [MIN_PROD_W-1:0] min_prod;
    logic [SUM_W-1:0]      min_mul;
    logic [SUM_W-1:0]      rem_full;
    logic [SEC_PROD_W-1:0] sec_prod;
    logic [REM_W-1:0]      sec_mul;
    logic [REM_W-1:0]      frm_full;

    assign cfg_ready = (state_reg == ctrb_pkg::MSF_IDLE);
    assign busy      = !cfg_ready;
    assign capacity  = cap_reg;
    assign lead_out  = lo_reg;

    // minutes = (total / 4) / (frames per minute / 4), exact over the full range
    assign min_prod = MIN_PROD_W'(tot_reg[SUM_W-1:2]) * MIN_PROD_W'(MIN_RECIP);
    assign min_mul  = SUM_W'(minq_reg) * FPM_C;
    assign rem_full = tot_reg - min_mul;
    assign sec_prod = SEC_PROD_W'(rem_reg) * SEC_PROD_W'(SEC_RECIP);
    assign sec_mul  = REM_W'(sec_reg) * FPS_C;
    assign frm_full = rem_reg - sec_mul;

    always_comb
    begin
        state_next = state_reg;
        cap_next   = cap_reg;
        tot_next   = tot_reg;
        minq_next  = minq_reg;
        rem_next   = rem_reg;
        sec_next   = sec_reg;
        lo_next    = lo_reg;
        case (state_reg)
            ctrb_pkg::MSF_IDLE:
            begin
                if (cfg_valid)
                begin
                    cap_next   = cfg_data;
                    tot_next   = {1'b0, cfg_data} + SUM_W'(ctrb_pkg::LEAD_IN);
                    state_next = ctrb_pkg::MSF_MIN;
                end
            end
            ctrb_pkg::MSF_MIN:
            begin
                minq_next  = min_prod[MIN_SHIFT +: MIN_Q_W];
                state_next = ctrb_pkg::MSF_REM;
            end
            ctrb_pkg::MSF_REM:
            begin
                rem_next   = rem_full[REM_W-1:0];
                state_next = ctrb_pkg::MSF_SEC;
            end
            ctrb_pkg::MSF_SEC:
            begin
                sec_next   = sec_prod[SEC_SHIFT +: BYTE_W];
                state_next = ctrb_pkg::MSF_FRAME;
            end
            ctrb_pkg::MSF_FRAME:
            begin
                lo_next.m  = minq_reg[BYTE_W-1:0];
                lo_next.s  = sec_reg;
                lo_next.f  = frm_full[BYTE_W-1:0];
                state_next = ctrb_pkg::MSF_IDLE;
            end
            default:
            begin
                state_next = ctrb_pkg::MSF_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctrb_pkg::MSF_IDLE;
            cap_reg   <= '0;
            // lead-out of an empty disc: 00:02:00
            lo_reg.m  <= 8'd0;
            lo_reg.s  <= 8'd2;
            lo_reg.f  <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            lo_reg    <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg  <= tot_next;
        minq_reg <= minq_next;
        rem_reg  <= rem_next;
        sec_reg  <= sec_next;
    end

endmodule

`default_nettype wire

>>> rtl/ctrb_back.sv
// ----------------------------------------------------------------------------
// ctrb_back
// Walks one queued reply at a time and emits it through an output register,
// a byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrb_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              head_valid,
    input  ctrb_pkg::desc_t                        head_desc,
    output logic                                   pop,
    input  wire logic [ctrb_pkg::CAP_W-1:0]        capacity,
    input  ctrb_pkg::msf_t                         lead_out,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ctrb_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser
);

    localparam int IDX_W = ctrb_pkg::IDX_W;
    localparam int BYTE_W = ctrb_pkg::BYTE_W;

    logic              active_reg, active_next;
    ctrb_pkg::desc_t   desc_reg, desc_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;
    logic              out_rej_reg, out_rej_next;

    ctrb_pkg::desc_t   cur;
    logic [IDX_W-1:0]  cur_idx;
    logic              have;
    logic              advance;
    logic              is_last;

    assign cur     = active_reg ? desc_reg : head_desc;
    assign cur_idx = active_reg ? idx_reg : '0;
    assign have    = active_reg || head_valid;
    assign advance = !out_valid_reg || m_tready;
    assign is_last = (cur_idx == ctrb_pkg::last_index(cur.kind));
    assign pop     = advance && !active_reg && head_valid;

    always_comb
    begin
        active_next    = active_reg;
        desc_next      = desc_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_rej_next   = out_rej_reg;
        if (advance)
        begin
            out_valid_next = have;
            if (have)
            begin
                out_byte_next = ctrb_pkg::reply_byte(cur, cur_idx, capacity, lead_out);
                out_idx_next  = cur_idx;
                out_last_next = is_last;
                out_rej_next  = (cur.kind == ctrb_pkg::KIND_REJECT);
                desc_next     = cur;
                idx_next      = cur_idx + 1'b1;
                active_next   = !is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_rej_reg  <= out_rej_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_idx_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_rej_reg;

endmodule

`default_nettype wire

>>> rtl/cdrom_toc_response_builder_core.sv
// ----------------------------------------------------------------------------
// cdrom_toc_response_builder_core
// READ TOC reply generator for a single-track, single-session data disc.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry request queue has room and no
// capacity update is in progress; the reply then streams out one byte per
// cycle while the output is not stalled: 20, 12, 48 or 4 bytes for formats
// 0, 1, 2 and 5, and a single rejection transaction (tuser high, tlast high,
// data zero) for a bad format or a starting track above 1. Replies follow
// each other with no gap, so the output sets the rate. Writing the capacity
// register starts a conversion of capacity+150 into minute/second/frame (a
// reciprocal multiply and a remainder step for the minutes, then the same
// for the seconds and frames); cfg_ready and s_axis_tready stay low until it
// is done.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrom_toc_response_builder_core #(
    parameter int QUEUE_DEPTH = ctrb_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // toc_format[2:0], use_msf[3], first_track[11:4], zero[15:12]
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ctrb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // data_byte[7:0], byte_index[13:8], zero[15:14]
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [ctrb_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast,
    // status[0]
    output logic                                   m_axis_tuser,
    // capacity_blocks
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ctrb_pkg::CAP_W-1:0]        cfg_data
);

    logic                        msf_busy;
    logic [ctrb_pkg::CAP_W-1:0]  capacity;
    ctrb_pkg::msf_t              lead_out;
    logic                        push;
    ctrb_pkg::desc_t             push_desc;
    logic                        queue_full;
    logic                        pop;
    logic                        head_valid;
    ctrb_pkg::desc_t             head_desc;

    ctrb_msf u_msf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .capacity  (capacity),
        .lead_out  (lead_out),
        .busy      (msf_busy)
    );

    ctrb_front u_front (
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .msf_busy   (msf_busy),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    ctrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    ctrb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .capacity   (capacity),
        .lead_out   (lead_out),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast),
        .m_tuser    (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/ctrb_checker.sv
// ----------------------------------------------------------------------------
// ctrb_checker
// Port-level checks of the TOC response builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cdrom_toc_response_builder_core_macros.svh"

module ctrb_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        m_axis_tuser
);

    // stalled transaction holds
    `CTRB_ASSERT_IMP(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)), "output changed while stalled")

    // a rejection is a single zero byte marked last
    `CTRB_ASSERT_IMP(a_reject_form, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 16'h0000), "malformed rejection")

    // replies end only at one of the four reply lengths
    `CTRB_ASSERT_IMP(a_last_len, clk, rst_n, m_axis_tvalid && m_axis_tlast && !m_axis_tuser, (m_axis_tdata[13:8] == 6'd3) || (m_axis_tdata[13:8] == 6'd11) || (m_axis_tdata[13:8] == 6'd19) || (m_axis_tdata[13:8] == 6'd47), "reply ended at a bad length")

    // bytes of one reply follow without gaps and in order
    `CTRB_ASSERT_IMP(a_idx_step, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, ##1 (m_axis_tvalid && (m_axis_tdata[13:8] == $past(m_axis_tdata[13:8]) + 6'd1)), "byte index did not advance")

    // a new reply starts at byte zero
    `CTRB_ASSERT_IMP(a_idx_start, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, ##1 (!m_axis_tvalid || (m_axis_tdata[13:8] == 6'd0)), "reply did not start at byte zero")

endmodule

bind cdrom_toc_response_builder_core ctrb_checker u_ctrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
